// ===== design/xmi_event_parser_macros.svh =====
// ----------------------------------------------------------------------------
// xmi_event_parser_macros.svh
// Assertion macros used by the event parser checker.
// ----------------------------------------------------------------------------
`ifndef XMI_EVENT_PARSER_MACROS_SVH
`define XMI_EVENT_PARSER_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define XEP_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define XEP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/xep_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xep_pkg
// Types and constants of the extended-MIDI event chunk parser.
// ----------------------------------------------------------------------------
package xep_pkg;

  // Result status codes
  localparam logic [1:0] OUT_EVENT = 2'd0;
  localparam logic [1:0] OUT_DONE  = 2'd1;
  localparam logic [1:0] OUT_ERROR = 2'd2;

  // Event kinds
  localparam logic [1:0] KIND_ON   = 2'd0;
  localparam logic [1:0] KIND_OFF  = 2'd1;
  localparam logic [1:0] KIND_PROG = 2'd2;
  localparam logic [1:0] KIND_VOL  = 2'd3;

  // Payload byte counts
  localparam logic [1:0] CNT_NOTE_ON = 2'd3;
  localparam logic [1:0] CNT_OTHER   = 2'd2;

  // Status bytes, status high nibbles, a meta type and a controller number
  localparam logic [7:0] STS_META     = 8'hFF;
  localparam logic [7:0] STS_SYSEX    = 8'hF0;
  localparam logic [7:0] STS_ESCAPE   = 8'hF7;
  localparam logic [7:0] META_TRK_END = 8'h2F;
  localparam logic [7:0] CTRL_VOLUME  = 8'h07;
  localparam logic [3:0] NIB_NOTE_OFF = 4'h8;
  localparam logic [3:0] NIB_NOTE_ON  = 4'h9;
  localparam logic [3:0] NIB_POLY_AT  = 4'hA;
  localparam logic [3:0] NIB_CTRL     = 4'hB;
  localparam logic [3:0] NIB_PROG     = 4'hC;
  localparam logic [3:0] NIB_CHAN_AT  = 4'hD;
  localparam logic [3:0] NIB_BEND     = 4'hE;

  // Most results one byte can cause
  localparam int unsigned MaxResults = 3;

  typedef struct packed {
    logic [1:0]  out_status;
    logic [31:0] event_time;
    logic [31:0] event_order;
    logic [1:0]  event_kind;
    logic [3:0]  channel;
    logic [7:0]  data_first;
    logic [7:0]  data_second;
    logic [1:0]  data_count;
    logic [31:0] event_total;
    logic        out_last;
  } result_t;

  // All results caused by one accepted byte
  typedef struct packed {
    logic [1:0]                 count;
    result_t [MaxResults-1:0]   res;
  } bundle_t;

endpackage

// ===== design/xep_ifs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xep_ifs
// Valid/ready channels for chunk bytes in and parse results out.
// ----------------------------------------------------------------------------
interface xep_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       chunk_last;

  modport source (output valid, output in_byte, output chunk_last, input ready);
  modport sink   (input valid, input in_byte, input chunk_last, output ready);
  modport monitor (input valid, input ready, input in_byte, input chunk_last);
endinterface

interface xep_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  out_status;
  logic [31:0] event_time;
  logic [31:0] event_order;
  logic [1:0]  event_kind;
  logic [3:0]  channel;
  logic [7:0]  data_first;
  logic [7:0]  data_second;
  logic [1:0]  data_count;
  logic [31:0] event_total;
  logic        out_last;

  modport source (
    output valid, output out_status, output event_time, output event_order,
    output event_kind, output channel, output data_first, output data_second,
    output data_count, output event_total, output out_last, input ready
  );
  modport sink (
    input valid, input out_status, input event_time, input event_order,
    input event_kind, input channel, input data_first, input data_second,
    input data_count, input event_total, input out_last, output ready
  );
  modport monitor (
    input valid, input ready, input out_status, input event_time,
    input event_order, input event_kind, input channel, input data_first,
    input data_second, input data_count, input event_total, input out_last
  );
endinterface

// ===== design/xep_parse_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xep_parse_core
// Parse state machine: one accepted byte updates the state and yields the
// bundle of results it causes, all in the same cycle.
// ----------------------------------------------------------------------------
module xep_parse_core #(
  parameter int unsigned TIME_BITS        = 32,
  parameter int unsigned LENGTH_MAX_BYTES = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  logic [7:0]        in_byte_i,
  input  logic              chunk_last_i,
  output xep_pkg::bundle_t  bundle_o
);

  localparam int unsigned TW = TIME_BITS;
  localparam int unsigned LW = 7 * LENGTH_MAX_BYTES;
  localparam int unsigned SW = $clog2(LENGTH_MAX_BYTES + 1);

  typedef enum logic [3:0] {
    PH_IDLE, PH_META_TYPE, PH_LENGTH, PH_SKIP, PH_NOTE_KEY, PH_NOTE_VEL,
    PH_NOTE_DUR, PH_ONE_DATA, PH_TWO_FIRST, PH_TWO_SECOND, PH_ENDED
  } phase_e;

  phase_e          phase_q, phase_d;
  logic [TW-1:0]   time_q, time_d;
  logic [31:0]     ord_q, ord_d;
  logic [7:0]      status_q, status_d;
  logic            meta_end_q, meta_end_d;
  logic [LW-1:0]   len_q, len_d;
  logic [SW-1:0]   seen_q, seen_d;
  logic [LW-1:0]   skip_q, skip_d;
  logic [7:0]      first_q, first_d;
  logic [7:0]      second_q, second_d;
  logic [31:0]     emit_q, emit_d;
  logic            err_q, err_d;
  logic            ended_q, ended_d;

  logic [LW-1:0]   len_step;
  logic [SW-1:0]   seen_inc;
  logic            len_over;
  logic            len_more;
  logic [TW-1:0]   off_time;
  logic            bad;
  logic [1:0]      n_res;
  xep_pkg::result_t [xep_pkg::MaxResults-1:0] res_w;

  function automatic xep_pkg::result_t make_event(
    logic [31:0] t, logic [31:0] ord, logic [1:0] kind, logic [3:0] ch,
    logic [7:0] d1, logic [7:0] d2, logic [1:0] cnt, logic [31:0] total
  );
    xep_pkg::result_t r;
    r.out_status  = xep_pkg::OUT_EVENT;
    r.event_time  = t;
    r.event_order = ord;
    r.event_kind  = kind;
    r.channel     = ch;
    r.data_first  = d1;
    r.data_second = d2;
    r.data_count  = cnt;
    r.event_total = total;
    r.out_last    = 1'b0;
    return r;
  endfunction

  // Variable-length field: shift in seven bits, check continuation
  assign len_step = (len_q << 7) | LW'(in_byte_i[6:0]);
  assign seen_inc = seen_q + SW'(1);
  assign len_over = in_byte_i[7] && (seen_inc >= SW'(LENGTH_MAX_BYTES));
  assign len_more = in_byte_i[7] && !len_over;
  assign off_time = time_q + TW'(len_step);

  // Next state and results for the accepted byte
  always_comb begin
    phase_d    = phase_q;
    time_d     = time_q;
    ord_d      = ord_q;
    status_d   = status_q;
    meta_end_d = meta_end_q;
    len_d      = len_q;
    seen_d     = seen_q;
    skip_d     = skip_q;
    first_d    = first_q;
    second_d   = second_q;
    emit_d     = emit_q;
    err_d      = err_q;
    ended_d    = ended_q;
    n_res      = 2'd0;
    res_w      = '0;
    bad        = 1'b0;

    if (fire_i && !err_q && !ended_q) begin
      unique case (phase_q)
        PH_IDLE: begin
          if (!in_byte_i[7]) begin
            time_d = time_q + TW'(in_byte_i);
          end else begin
            status_d = in_byte_i;
            len_d    = '0;
            seen_d   = '0;
            priority if (in_byte_i == xep_pkg::STS_META) begin
              phase_d = PH_META_TYPE;
            end else if (in_byte_i == xep_pkg::STS_SYSEX ||
                         in_byte_i == xep_pkg::STS_ESCAPE) begin
              phase_d = PH_LENGTH;
            end else if (in_byte_i[7:4] == xep_pkg::NIB_NOTE_ON) begin
              phase_d = PH_NOTE_KEY;
            end else if (in_byte_i[7:4] == xep_pkg::NIB_PROG ||
                         in_byte_i[7:4] == xep_pkg::NIB_CHAN_AT) begin
              phase_d = PH_ONE_DATA;
            end else if (in_byte_i[7:4] == xep_pkg::NIB_NOTE_OFF ||
                         in_byte_i[7:4] == xep_pkg::NIB_POLY_AT ||
                         in_byte_i[7:4] == xep_pkg::NIB_CTRL ||
                         in_byte_i[7:4] == xep_pkg::NIB_BEND) begin
              phase_d = PH_TWO_FIRST;
            end else begin
              err_d = 1'b1;
            end
          end
        end
        PH_META_TYPE: begin
          meta_end_d = (in_byte_i == xep_pkg::META_TRK_END);
          phase_d    = PH_LENGTH;
        end
        PH_LENGTH: begin
          len_d  = len_step;
          seen_d = seen_inc;
          if (len_over) begin
            err_d = 1'b1;
          end else if (!len_more) begin
            if (len_step != '0) begin
              skip_d  = len_step;
              phase_d = PH_SKIP;
            end else if (status_q == xep_pkg::STS_META && meta_end_q) begin
              phase_d = PH_ENDED;
              ended_d = 1'b1;
            end else begin
              ord_d   = ord_q + 32'd1;
              phase_d = PH_IDLE;
            end
          end
        end
        PH_SKIP: begin
          skip_d = skip_q - LW'(1);
          if (skip_q == LW'(1)) begin
            if (status_q == xep_pkg::STS_META && meta_end_q) begin
              phase_d = PH_ENDED;
              ended_d = 1'b1;
            end else begin
              ord_d   = ord_q + 32'd1;
              phase_d = PH_IDLE;
            end
          end
        end
        PH_NOTE_KEY: begin
          first_d = in_byte_i;
          phase_d = PH_NOTE_VEL;
        end
        PH_NOTE_VEL: begin
          second_d = in_byte_i;
          phase_d  = PH_NOTE_DUR;
        end
        PH_NOTE_DUR: begin
          len_d  = len_step;
          seen_d = seen_inc;
          if (len_over) begin
            err_d = 1'b1;
          end else if (!len_more) begin
            res_w[0] = make_event(32'(time_q), ord_q, xep_pkg::KIND_ON,
                                  status_q[3:0], first_q, second_q,
                                  xep_pkg::CNT_NOTE_ON, emit_q + 32'd1);
            res_w[1] = make_event(32'(off_time), ord_q + 32'd1,
                                  xep_pkg::KIND_OFF, status_q[3:0], first_q,
                                  8'd0, xep_pkg::CNT_OTHER, emit_q + 32'd2);
            n_res   = 2'd2;
            ord_d   = ord_q + 32'd2;
            emit_d  = emit_q + 32'd2;
            phase_d = PH_IDLE;
          end
        end
        PH_ONE_DATA: begin
          if (status_q[7:4] == xep_pkg::NIB_PROG) begin
            res_w[0] = make_event(32'(time_q), ord_q, xep_pkg::KIND_PROG,
                                  status_q[3:0], in_byte_i, 8'd0,
                                  xep_pkg::CNT_OTHER, emit_q + 32'd1);
            n_res  = 2'd1;
            emit_d = emit_q + 32'd1;
          end
          ord_d   = ord_q + 32'd1;
          phase_d = PH_IDLE;
        end
        PH_TWO_FIRST: begin
          first_d = in_byte_i;
          phase_d = PH_TWO_SECOND;
        end
        PH_TWO_SECOND: begin
          priority if (status_q[7:4] == xep_pkg::NIB_NOTE_OFF) begin
            res_w[0] = make_event(32'(time_q), ord_q, xep_pkg::KIND_OFF,
                                  status_q[3:0], first_q, 8'd0,
                                  xep_pkg::CNT_OTHER, emit_q + 32'd1);
            n_res  = 2'd1;
            emit_d = emit_q + 32'd1;
          end else if (status_q[7:4] == xep_pkg::NIB_CTRL &&
                       first_q == xep_pkg::CTRL_VOLUME) begin
            res_w[0] = make_event(32'(time_q), ord_q, xep_pkg::KIND_VOL,
                                  status_q[3:0], in_byte_i, 8'd0,
                                  xep_pkg::CNT_OTHER, emit_q + 32'd1);
            n_res  = 2'd1;
            emit_d = emit_q + 32'd1;
          end else begin
            n_res = 2'd0;
          end
          ord_d   = ord_q + 32'd1;
          phase_d = PH_IDLE;
        end
        default: begin
          phase_d = PH_ENDED;
        end
      endcase
    end

    // Last byte: final verdict, then back to reset values
    if (fire_i && chunk_last_i) begin
      bad = err_d || (phase_d != PH_IDLE && phase_d != PH_ENDED);
      res_w[n_res]            = '0;
      res_w[n_res].out_status = bad ? xep_pkg::OUT_ERROR : xep_pkg::OUT_DONE;
      res_w[n_res].event_total = bad ? 32'd0 : emit_d;
      n_res      = n_res + 2'd1;
      phase_d    = PH_IDLE;
      time_d     = '0;
      ord_d      = '0;
      status_d   = '0;
      meta_end_d = 1'b0;
      len_d      = '0;
      seen_d     = '0;
      skip_d     = '0;
      first_d    = '0;
      second_d   = '0;
      emit_d     = '0;
      err_d      = 1'b0;
      ended_d    = 1'b0;
    end

    // Flag the last result of this byte
    if (n_res != 2'd0) begin
      res_w[n_res - 2'd1].out_last = 1'b1;
    end
  end

  assign bundle_o.count = n_res;
  assign bundle_o.res   = res_w;

  // Parse state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      time_q     <= '0;
      ord_q      <= '0;
      status_q   <= '0;
      meta_end_q <= 1'b0;
      len_q      <= '0;
      seen_q     <= '0;
      skip_q     <= '0;
      first_q    <= '0;
      second_q   <= '0;
      emit_q     <= '0;
      err_q      <= 1'b0;
      ended_q    <= 1'b0;
    end else if (fire_i) begin
      phase_q    <= phase_d;
      time_q     <= time_d;
      ord_q      <= ord_d;
      status_q   <= status_d;
      meta_end_q <= meta_end_d;
      len_q      <= len_d;
      seen_q     <= seen_d;
      skip_q     <= skip_d;
      first_q    <= first_d;
      second_q   <= second_d;
      emit_q     <= emit_d;
      err_q      <= err_d;
      ended_q    <= ended_d;
    end
  end

endmodule

// ===== design/xep_res_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xep_res_queue
// Result register: holds the bundle of one byte and hands its results out
// one per ready cycle. A new bundle loads while empty or as the last held result is taken.
// ----------------------------------------------------------------------------
module xep_res_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  xep_pkg::bundle_t  bundle_i,
  output logic              can_load_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output xep_pkg::result_t  result_o
);

  logic             busy_q;
  logic [1:0]       idx_q;
  xep_pkg::bundle_t bundle_q;
  logic             out_fire;
  logic             at_end;

  assign out_fire    = busy_q && out_ready_i;
  assign at_end      = (idx_q == bundle_q.count - 2'd1);
  assign can_load_o  = !busy_q || (out_fire && at_end);
  assign out_valid_o = busy_q;
  assign result_o    = bundle_q.res[idx_q];

  // Control: busy flag and read index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= 2'd0;
    end else if (load_i) begin
      busy_q <= 1'b1;
      idx_q  <= 2'd0;
    end else if (out_fire) begin
      if (at_end) begin
        busy_q <= 1'b0;
        idx_q  <= 2'd0;
      end else begin
        idx_q <= idx_q + 2'd1;
      end
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      bundle_q <= bundle_i;
    end
  end

endmodule

// ===== design/xmi_event_parser.sv =====
`timescale 1ns / 1ps
// The first result of a byte is offered in the cycle after the byte is taken.
// Throughput: one byte per cycle while each byte gives at most one result and
//   out_o.ready stays high; a byte giving more results (at most 3) stalls the
//   input, and the next byte is taken in the cycle its last result is taken.
// Reset: rst_ni low clears all parse state and drops any pending results.
// ----------------------------------------------------------------------------
// xmi_event_parser
// Byte-serial parser of one extended-MIDI event chunk into timed events.
// ----------------------------------------------------------------------------
module xmi_event_parser #(
  parameter int unsigned TIME_BITS        = 32,
  parameter int unsigned LENGTH_MAX_BYTES = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  xep_in_if.sink     in_i,
  xep_out_if.source  out_o
);

  logic             in_fire;
  logic             can_load;
  xep_pkg::bundle_t bundle;
  xep_pkg::result_t result;

  assign in_i.ready = can_load;
  assign in_fire    = in_i.valid && can_load;

  // Parse state machine
  xep_parse_core #(
    .TIME_BITS        (TIME_BITS),
    .LENGTH_MAX_BYTES (LENGTH_MAX_BYTES)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (in_fire),
    .in_byte_i    (in_i.in_byte),
    .chunk_last_i (in_i.chunk_last),
    .bundle_o     (bundle)
  );

  // Result register and serializer
  xep_res_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (in_fire && (bundle.count != 2'd0)),
    .bundle_i    (bundle),
    .can_load_o  (can_load),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .result_o    (result)
  );

  assign out_o.out_status  = result.out_status;
  assign out_o.event_time  = result.event_time;
  assign out_o.event_order = result.event_order;
  assign out_o.event_kind  = result.event_kind;
  assign out_o.channel     = result.channel;
  assign out_o.data_first  = result.data_first;
  assign out_o.data_second = result.data_second;
  assign out_o.data_count  = result.data_count;
  assign out_o.event_total = result.event_total;
  assign out_o.out_last    = result.out_last;

endmodule

// ===== design/xep_checker.sv =====
`timescale 1ns / 1ps
`include "xmi_event_parser_macros.svh"
// ----------------------------------------------------------------------------
// xep_checker
// Port-level checks of the event parser, bound to the top level.
// ----------------------------------------------------------------------------
module xep_checker (
  input logic       clk_i,
  input logic       rst_ni,
  xep_in_if.sink    in_i,
  xep_out_if.source out_o
);

  // A done or error result always closes the results of its byte
  `XEP_ASSERT_NOW(a_final_is_last, clk_i, rst_ni,
    out_o.valid && out_o.out_status != xep_pkg::OUT_EVENT,
    out_o.out_last, "done/error result without last flag")

  // Note-on events carry three payload bytes, all others two
  `XEP_ASSERT_NOW(a_count_kind, clk_i, rst_ni,
    out_o.valid && out_o.out_status == xep_pkg::OUT_EVENT,
    (out_o.event_kind == xep_pkg::KIND_ON) == (out_o.data_count == xep_pkg::CNT_NOTE_ON),
    "data count does not match event kind")

  // Final results carry no event time or order
  `XEP_ASSERT_NOW(a_final_zero, clk_i, rst_ni,
    out_o.valid && out_o.out_status != xep_pkg::OUT_EVENT,
    out_o.event_time == 32'd0 && out_o.event_order == 32'd0,
    "final result with nonzero time or order")

  // The last byte of a chunk always produces a result next cycle
  `XEP_ASSERT_NEXT(a_last_answers, clk_i, rst_ni,
    in_i.valid && in_i.ready && in_i.chunk_last,
    out_o.valid, "no result after last byte")

  // A stalled result holds
  `XEP_ASSERT_NEXT(a_out_hold, clk_i, rst_ni,
    out_o.valid && !out_o.ready,
    out_o.valid && $stable(out_o.event_time) && $stable(out_o.event_order) &&
      $stable(out_o.out_status),
    "stalled result changed")

endmodule

bind xmi_event_parser xep_checker u_xep_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .in_i   (in_i),
  .out_o  (out_o)
);

// ===== tb/xmi_event_parser_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xmi_event_parser_tb
// Self-checking bench for the event chunk parser. Chunks of bytes are sent one
// request at a time with random gaps. A local parse model predicts every
// event, done and error result, and each result taken from the block is
// compared field by field against the oldest prediction. Directed chunks
// cover each status kind and the error paths. Random chunks follow.
// ----------------------------------------------------------------------------
module xmi_event_parser_tb;

  localparam int unsigned StallLimit   = 500;
  localparam int unsigned DrainCycles  = 20;
  localparam int unsigned RandomItems  = 100;
  localparam int unsigned SteadyItems  = 40;
  localparam logic [7:0]  StsUndefined = 8'hF4;
  localparam logic [7:0]  VlqMore      = 8'h80;

  typedef enum logic [3:0] {
    PS_WAIT, PS_META_TYPE, PS_LENGTH, PS_SKIP, PS_NOTE_KEY, PS_NOTE_VEL,
    PS_NOTE_DUR, PS_ONE_DATA, PS_TWO_FIRST, PS_TWO_SECOND, PS_ENDED
  } parse_state_e;

  logic clk;
  logic rst_n;

  xep_in_if  byte_if ();
  xep_out_if res_if ();

  xmi_event_parser i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (byte_if),
    .out_o  (res_if)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Model state of the parser
  parse_state_e phase;
  logic [31:0]  cur_time;
  logic [31:0]  order_num;
  logic [7:0]   status_reg;
  logic         is_end_meta;
  logic [27:0]  len_acc;
  int unsigned  len_cnt;
  logic [27:0]  skip_cnt;
  logic [7:0]   hold_a;
  logic [7:0]   hold_b;
  logic [31:0]  event_cnt;
  logic         err_seen;
  logic         track_done;

  xep_pkg::result_t byte_results[$];
  xep_pkg::result_t results_due[$];
  logic [7:0]   chunk_bytes[$];
  int unsigned  bytes_sent;
  int unsigned  mismatch_count;
  bit           idling_on;

  task automatic clear_parser();
    phase       = PS_WAIT;
    cur_time    = '0;
    order_num   = '0;
    status_reg  = '0;
    is_end_meta = 1'b0;
    len_acc     = '0;
    len_cnt     = 0;
    skip_cnt    = '0;
    hold_a      = '0;
    hold_b      = '0;
    event_cnt   = '0;
    err_seen    = 1'b0;
    track_done  = 1'b0;
  endtask

  task automatic push_event(input logic [31:0] t, input logic [1:0] kind,
                            input logic [7:0] d1, input logic [7:0] d2,
                            input logic [1:0] cnt);
    xep_pkg::result_t r;
    r             = '0;
    event_cnt     = event_cnt + 1;
    r.out_status  = xep_pkg::OUT_EVENT;
    r.event_time  = t;
    r.event_order = order_num;
    r.event_kind  = kind;
    r.channel     = status_reg[3:0];
    r.data_first  = d1;
    r.data_second = d2;
    r.data_count  = cnt;
    r.event_total = event_cnt;
    byte_results.push_back(r);
    order_num     = order_num + 1;
  endtask

  // One byte of a variable-length value: 0 more to come, 1 done, 2 too long
  function automatic int vlq_step(input logic [7:0] b);
    len_acc = {len_acc[20:0], b[6:0]};
    len_cnt++;
    if (!b[7]) return 1;
    if (len_cnt >= 4) return 2;
    return 0;
  endfunction

  task automatic close_skipped();
    if (status_reg == xep_pkg::STS_META && is_end_meta) begin
      phase      = PS_ENDED;
      track_done = 1'b1;
    end else begin
      order_num = order_num + 1;
      phase     = PS_WAIT;
    end
  endtask

  // Predict the results of one accepted byte
  task automatic parse_chunk_byte(input logic [7:0] b, input logic last);
    logic [3:0]       nib;
    int               vs;
    xep_pkg::result_t fin;
    byte_results.delete();
    if (!err_seen && !track_done) begin
      case (phase)
        PS_WAIT: begin
          if (!b[7]) begin
            cur_time = cur_time + {24'd0, b};
          end else begin
            status_reg = b;
            nib        = b[7:4];
            len_acc    = '0;
            len_cnt    = 0;
            if (b == xep_pkg::STS_META) phase = PS_META_TYPE;
            else if (b == xep_pkg::STS_SYSEX || b == xep_pkg::STS_ESCAPE)
              phase = PS_LENGTH;
            else if (nib == xep_pkg::NIB_NOTE_ON) phase = PS_NOTE_KEY;
            else if (nib == xep_pkg::NIB_PROG || nib == xep_pkg::NIB_CHAN_AT)
              phase = PS_ONE_DATA;
            else if (nib == xep_pkg::NIB_NOTE_OFF || nib == xep_pkg::NIB_POLY_AT ||
                     nib == xep_pkg::NIB_CTRL || nib == xep_pkg::NIB_BEND)
              phase = PS_TWO_FIRST;
            else err_seen = 1'b1;
          end
        end
        PS_META_TYPE: begin
          is_end_meta = (b == xep_pkg::META_TRK_END);
          phase       = PS_LENGTH;
        end
        PS_LENGTH: begin
          vs = vlq_step(b);
          if (vs == 2) begin
            err_seen = 1'b1;
          end else if (vs == 1) begin
            if (len_acc == '0) begin
              close_skipped();
            end else begin
              skip_cnt = len_acc;
              phase    = PS_SKIP;
            end
          end
        end
        PS_SKIP: begin
          skip_cnt = skip_cnt - 1;
          if (skip_cnt == '0) close_skipped();
        end
        PS_NOTE_KEY: begin
          hold_a = b;
          phase  = PS_NOTE_VEL;
        end
        PS_NOTE_VEL: begin
          hold_b = b;
          phase  = PS_NOTE_DUR;
        end
        PS_NOTE_DUR: begin
          vs = vlq_step(b);
          if (vs == 2) begin
            err_seen = 1'b1;
          end else if (vs == 1) begin
            push_event(cur_time, xep_pkg::KIND_ON, hold_a, hold_b,
                       xep_pkg::CNT_NOTE_ON);
            push_event(cur_time + {4'd0, len_acc}, xep_pkg::KIND_OFF, hold_a, 8'd0,
                       xep_pkg::CNT_OTHER);
            phase = PS_WAIT;
          end
        end
        PS_ONE_DATA: begin
          if (status_reg[7:4] == xep_pkg::NIB_PROG)
            push_event(cur_time, xep_pkg::KIND_PROG, b, 8'd0, xep_pkg::CNT_OTHER);
          else order_num = order_num + 1;
          phase = PS_WAIT;
        end
        PS_TWO_FIRST: begin
          hold_a = b;
          phase  = PS_TWO_SECOND;
        end
        PS_TWO_SECOND: begin
          if (status_reg[7:4] == xep_pkg::NIB_NOTE_OFF)
            push_event(cur_time, xep_pkg::KIND_OFF, hold_a, 8'd0, xep_pkg::CNT_OTHER);
          else if (status_reg[7:4] == xep_pkg::NIB_CTRL && hold_a == xep_pkg::CTRL_VOLUME)
            push_event(cur_time, xep_pkg::KIND_VOL, b, 8'd0, xep_pkg::CNT_OTHER);
          else
            order_num = order_num + 1;
          phase = PS_WAIT;
        end
        default: phase = PS_ENDED;
      endcase
    end
    if (last) begin
      fin = '0;
      if (err_seen || (phase != PS_WAIT && phase != PS_ENDED)) begin
        fin.out_status = xep_pkg::OUT_ERROR;
      end else begin
        fin.out_status  = xep_pkg::OUT_DONE;
        fin.event_total = event_cnt;
      end
      byte_results.push_back(fin);
      clear_parser();
    end
    if (byte_results.size() > 0) byte_results[byte_results.size()-1].out_last = 1'b1;
    foreach (byte_results[i]) results_due.push_back(byte_results[i]);
  endtask

  // Send one byte; returns after the request is taken
  task automatic send_byte(input logic [7:0] b, input logic last);
    if (idling_on && $urandom_range(0, 3) == 0) begin
      byte_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    byte_if.valid      <= 1'b1;
    byte_if.in_byte    <= b;
    byte_if.chunk_last <= last;
    @(posedge clk);
    while (!byte_if.ready) @(posedge clk);
    parse_chunk_byte(b, last);
    bytes_sent++;
  endtask

  task automatic send_chunk();
    foreach (chunk_bytes[i]) send_byte(chunk_bytes[i], i == chunk_bytes.size() - 1);
    chunk_bytes.delete();
  endtask

  task automatic add_vlq(input int unsigned value, input int nb);
    logic [7:0] bv;
    for (int i = nb - 1; i >= 0; i--) begin
      bv = 8'((value >> (7 * i)) & 32'h7F);
      if (i > 0) bv = bv | VlqMore;
      chunk_bytes.push_back(bv);
    end
  endtask

  // Mostly well-formed events with random content, some noise
  task automatic build_random_chunk(input int n_events);
    int          pick;
    int          nb;
    int unsigned len;
    logic [3:0]  ch;
    for (int e = 0; e < n_events; e++) begin
      pick = $urandom_range(0, 99);
      ch   = 4'($urandom_range(0, 15));
      if (pick < 25) begin
        chunk_bytes.push_back(8'($urandom_range(0, 127)));
      end else if (pick < 40) begin
        chunk_bytes.push_back({xep_pkg::NIB_NOTE_ON, ch});
        chunk_bytes.push_back(8'($urandom));
        chunk_bytes.push_back(8'($urandom));
        nb = $urandom_range(1, 4);
        add_vlq($urandom & ((32'd1 << (7 * nb)) - 1), nb);
      end else if (pick < 48) begin
        chunk_bytes.push_back({xep_pkg::NIB_NOTE_OFF, ch});
        chunk_bytes.push_back(8'($urandom));
        chunk_bytes.push_back(8'($urandom));
      end else if (pick < 56) begin
        chunk_bytes.push_back({xep_pkg::NIB_PROG, ch});
        chunk_bytes.push_back(8'($urandom));
      end else if (pick < 64) begin
        chunk_bytes.push_back({xep_pkg::NIB_CTRL, ch});
        chunk_bytes.push_back(xep_pkg::CTRL_VOLUME);
        chunk_bytes.push_back(8'($urandom));
      end else if (pick < 70) begin
        chunk_bytes.push_back({xep_pkg::NIB_CTRL, ch});
        chunk_bytes.push_back(8'($urandom));
        chunk_bytes.push_back(8'($urandom));
      end else if (pick < 74) begin
        chunk_bytes.push_back({xep_pkg::NIB_POLY_AT, ch});
        chunk_bytes.push_back(8'($urandom));
        chunk_bytes.push_back(8'($urandom));
      end else if (pick < 78) begin
        chunk_bytes.push_back({xep_pkg::NIB_CHAN_AT, ch});
        chunk_bytes.push_back(8'($urandom));
      end else if (pick < 82) begin
        chunk_bytes.push_back({xep_pkg::NIB_BEND, ch});
        chunk_bytes.push_back(8'($urandom));
        chunk_bytes.push_back(8'($urandom));
      end else if (pick < 94) begin
        // sysex or meta with a short payload, length maybe padded
        if (pick < 88) begin
          chunk_bytes.push_back($urandom_range(0, 1) ? xep_pkg::STS_SYSEX
                                                     : xep_pkg::STS_ESCAPE);
        end else begin
          chunk_bytes.push_back(xep_pkg::STS_META);
          chunk_bytes.push_back(8'($urandom));
        end
        len = $urandom_range(0, 4);
        add_vlq(len, $urandom_range(1, 2));
        repeat (len) chunk_bytes.push_back(8'($urandom));
      end else if (pick < 97) begin
        chunk_bytes.push_back(8'($urandom));
      end else begin
        // duration with too many continuation bytes
        chunk_bytes.push_back({xep_pkg::NIB_NOTE_ON, ch});
        chunk_bytes.push_back(8'($urandom));
        chunk_bytes.push_back(8'($urandom));
        repeat (4) chunk_bytes.push_back(VlqMore | 8'($urandom_range(0, 127)));
      end
    end
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      chunk_bytes.push_back(xep_pkg::STS_META);
      chunk_bytes.push_back(xep_pkg::META_TRK_END);
      chunk_bytes.push_back(8'd0);
      repeat ($urandom_range(0, 3)) chunk_bytes.push_back(8'($urandom));
    end else if (pick == 1 && chunk_bytes.size() > 1) begin
      chunk_bytes.pop_back();
    end
    if (chunk_bytes.size() == 0) chunk_bytes.push_back(8'($urandom_range(0, 127)));
  endtask

  // Every status kind in one chunk, ending in a track end and an ignored byte
  task automatic test_directed_events();
    chunk_bytes = {8'h00, 8'h7F,
                   {xep_pkg::NIB_NOTE_ON, 4'hF}, 8'hFF, 8'h80, 8'hFF, 8'hFF, 8'hFF,
                   8'h7F,
                   {xep_pkg::NIB_NOTE_OFF, 4'h0}, 8'h3C, 8'h40,
                   {xep_pkg::NIB_PROG, 4'h5}, 8'h7F,
                   {xep_pkg::NIB_CTRL, 4'h2}, xep_pkg::CTRL_VOLUME, 8'hE4,
                   {xep_pkg::NIB_CTRL, 4'h1}, 8'h0A, 8'h20,
                   {xep_pkg::NIB_POLY_AT, 4'h0}, 8'h01, 8'h02,
                   {xep_pkg::NIB_CHAN_AT, 4'h3}, 8'h05,
                   {xep_pkg::NIB_BEND, 4'h0}, 8'h00, 8'h40,
                   xep_pkg::STS_SYSEX, 8'h00,
                   xep_pkg::STS_ESCAPE, 8'h01, 8'h11,
                   8'h05, {xep_pkg::NIB_NOTE_ON, 4'h0}, 8'h00, 8'h00, 8'h81, 8'h00,
                   xep_pkg::STS_META, xep_pkg::META_TRK_END, 8'h00,
                   {xep_pkg::NIB_NOTE_ON, 4'h1}};
    send_chunk();
  endtask

  // Unknown status, over-long duration, truncated event, delta-only chunk
  task automatic test_directed_errors();
    chunk_bytes = {StsUndefined};
    send_chunk();
    chunk_bytes = {{xep_pkg::NIB_NOTE_ON, 4'h4}, 8'h3C, 8'h40, 8'h80, 8'h80, 8'h80,
                   8'h80, 8'h01};
    send_chunk();
    chunk_bytes = {{xep_pkg::NIB_BEND, 4'h7}, 8'h05};
    send_chunk();
    chunk_bytes = {8'h00};
    send_chunk();
  endtask

  task automatic test_random_chunks();
    int unsigned stop_at;
    stop_at = bytes_sent + RandomItems;
    while (bytes_sent < stop_at) begin
      build_random_chunk($urandom_range(1, 12));
      send_chunk();
    end
  endtask

  // Final part without gaps or stalls
  task automatic test_back_to_back_chunks();
    int unsigned stop_at;
    idling_on = 1'b0;
    stop_at   = bytes_sent + SteadyItems;
    while (bytes_sent < stop_at) begin
      build_random_chunk($urandom_range(1, 8));
      send_chunk();
    end
  endtask

  // Result receiver with random stall bursts
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
        res_if.ready <= 1'b0;
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 3);
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // Compare each taken result with the oldest prediction
  always @(posedge clk) begin : result_check
    xep_pkg::result_t got;
    xep_pkg::result_t want;
    if (rst_n && res_if.valid && res_if.ready) begin
      got.out_status  = res_if.out_status;
      got.event_time  = res_if.event_time;
      got.event_order = res_if.event_order;
      got.event_kind  = res_if.event_kind;
      got.channel     = res_if.channel;
      got.data_first  = res_if.data_first;
      got.data_second = res_if.data_second;
      got.data_count  = res_if.data_count;
      got.event_total = res_if.event_total;
      got.out_last    = res_if.out_last;
      if (results_due.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("%0t: result with none expected", $realtime);
      end else begin
        want = results_due.pop_front();
        if (got.out_status !== want.out_status || got.event_time !== want.event_time ||
            got.event_order !== want.event_order || got.event_kind !== want.event_kind ||
            got.channel !== want.channel || got.data_first !== want.data_first ||
            got.data_second !== want.data_second || got.data_count !== want.data_count ||
            got.event_total !== want.event_total || got.out_last !== want.out_last) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display({"%0t: mismatch exp st=%0d t=%0h ord=%0d k=%0d ch=%0h d=%0h/%0h",
                      " n=%0d tot=%0d l=%0d"},
                     $realtime, want.out_status, want.event_time, want.event_order,
                     want.event_kind, want.channel, want.data_first, want.data_second,
                     want.data_count, want.event_total, want.out_last);
            $display({"%0t:          got st=%0d t=%0h ord=%0d k=%0d ch=%0h d=%0h/%0h",
                      " n=%0d tot=%0d l=%0d"},
                     $realtime, got.out_status, got.event_time, got.event_order,
                     got.event_kind, got.channel, got.data_first, got.data_second,
                     got.data_count, got.event_total, got.out_last);
          end
        end
      end
    end
  end

  // Ends the run when no request moves for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk);
      if ((byte_if.valid && byte_if.ready) || (res_if.valid && res_if.ready)) quiet = 0;
      else quiet++;
    end
    $display("xmi_event_parser_tb: FAIL");
    $finish;
  end

  initial begin : main_flow
    idling_on      = 1'b1;
    bytes_sent     = 0;
    mismatch_count = 0;
    clear_parser();
    rst_n              <= 1'b0;
    byte_if.valid      <= 1'b0;
    byte_if.in_byte    <= '0;
    byte_if.chunk_last <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_events();
    test_directed_errors();
    test_random_chunks();
    test_back_to_back_chunks();

    byte_if.valid <= 1'b0;
    while (results_due.size() > 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatch_count == 0 && results_due.size() == 0) begin
      $display("xmi_event_parser_tb: PASS");
    end else begin
      $display("xmi_event_parser_tb: FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+design
design/xep_pkg.sv
design/xep_ifs.sv
design/xep_parse_core.sv
design/xep_res_queue.sv
design/xmi_event_parser.sv
design/xep_checker.sv
tb/xmi_event_parser_tb.sv
